>>> hw/rtl/cascaded_bilinear_lowpass_iir_unit_assert.svh
// assertion macros shared by the cascaded low-pass filter rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef CASCADED_BILINEAR_LOWPASS_IIR_UNIT_ASSERT_SVH
`define CASCADED_BILINEAR_LOWPASS_IIR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CBLP_AST_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CBLP_AST_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/cblp_pkg.sv
// shared types and constants of the cascaded low-pass filter
// no dependencies; imported by controller, datapath and top level
`default_nettype none

package cblp_pkg;

   localparam int HIST_W     = 40;
   localparam int YL_W       = 16;
   localparam int OPB_W      = 25;
   localparam int POW_W      = 32;
   localparam int ACC_W      = 64;
   localparam int IDX_W      = 5;
   localparam int RLO_W      = 15;
   localparam int ORDER_W    = 4;
   localparam int GAIN_W     = 31;
   localparam int POLE_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLE  = 2'd2;

   localparam logic [ORDER_W-1:0]        ORDER_RST = 4'd2;
   localparam logic [GAIN_W-1:0]         GAIN_RST  = 31'd536870912;
   localparam logic signed [POW_W-1:0]   Q30_ONE   = 32'sd1073741824;
   localparam logic signed [ACC_W-1:0]   ACC_LIM   = 64'sh4000_0000_0000_0000;
   localparam logic signed [ACC_W-1:0]   HIST_LIM  = 64'sd549755813888;
   localparam logic signed [ACC_W-1:0]   RND29     = 64'sd536870912;
   localparam logic signed [ACC_W-1:0]   RND13     = 64'sd8192;

   typedef enum logic [3:0] {
      MOP_NONE,
      MOP_GPW_LO,
      MOP_GPW_HI,
      MOP_APW_LO,
      MOP_APW_HI,
      MOP_COEF_F,
      MOP_COEF_B,
      MOP_FWD,
      MOP_FB_HI,
      MOP_FB_LO
   } mul_op_type;

   typedef struct packed {
      mul_op_type       mop;
      logic [IDX_W-1:0] idx;
      logic             latch_item;
      logic             load_cfg;
      logic             binom_step;
      logic             take_sample;
      logic             prime_inc;
      logic             seed;
      logic             clear_acc;
      logic             finish;
   } dp_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0] order;
      logic             start_flag;
      logic             primed;
      logic             live;
      logic             out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/cblp_stream_if.sv
// valid/ready channel interfaces for filter samples and results
// no dependencies; used by the top level
`default_nettype none

interface cblp_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          record_start;
   modport source (output valid, sample_in, record_start, input ready);
   modport sink (input valid, sample_in, record_start, output ready);
endinterface

interface cblp_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          clipped;
   modport source (output valid, sample_out, clipped, input ready);
   modport sink (input valid, sample_out, clipped, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cascaded_bilinear_lowpass_iir_unit.sv
// top level of the cascaded bilinear low-pass iir filter
// depends on cblp_pkg, cblp_stream_if, cblp_ctrl and cblp_dp
//
//   channel   direction   handshake       payload
//   req_chan  in          valid/ready     sample_in, record_start
//   rsp_chan  out         valid/ready     sample_out, clipped
//   csr_*     in          csr_we only     csr_index, csr_wdata
//
// a sample's result is registered once the controller ends its multiply-accumulate loop; the next beat
// is taken only after that, back in idle; the beat that seeds the output history adds a seed step
// priming beats only shift the input history and return to idle
// a beat with record_start adds coefficient setup on the one shared multiplier
// the multiply-accumulate loop over 2n+1 taps on that multiplier sets the rate
// reset is synchronous; no clearing pass, tables read as zero until the first start
// a held result does not block the next beat; only the final store waits for rsp ready
`default_nettype none

module cascaded_bilinear_lowpass_iir_unit #(
   parameter int SECT_MAX    = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   cblp_req_if.sink                            req_chan,
   cblp_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [cblp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cblp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cblp_pkg::*;

   dp_cmd_type                    cmd;
   dp_stat_type                   stat;
   logic                          req_ready;
   logic                          rsp_valid;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          clipped;

   cblp_ctrl #(
      .SECT_MAX (SECT_MAX)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cblp_dp #(
      .SECT_MAX    (SECT_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sample_in    (req_chan.sample_in),
      .record_start (req_chan.record_start),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_valid),
      .sample_out   (sample_out),
      .clipped      (clipped)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.sample_out = sample_out;
   assign rsp_chan.clipped    = clipped;

endmodule

`default_nettype wire

>>> hw/rtl/cblp_dp.sv
// datapath: config registers, histories, coefficient tables, shared multiplier
// depends on cblp_pkg; driven by cblp_ctrl commands
`default_nettype none

module cblp_dp #(
   parameter int SECT_MAX    = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cblp_pkg::dp_cmd_type                   cmd,
   output cblp_pkg::dp_stat_type                  stat,
   input  logic                                   csr_we,
   input  logic [cblp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cblp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]          sample_in,
   input  logic                                   record_start,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]          sample_out,
   output logic                                   clipped
);
   import cblp_pkg::*;

   localparam int IW = $clog2(SECT_MAX + 1);
   localparam int CW = SECT_MAX + 32;
   localparam int RW = SECT_MAX;
   localparam int PW = CW + OPB_W;
   localparam int XW = (PW > ACC_W) ? PW : ACC_W;
   localparam logic [IW-1:0] N_MAX = IW'(SECT_MAX);
   localparam logic [IW-1:0] N_RST = (SECT_MAX < 2) ? IW'(1) : IW'(2);
   localparam logic signed [ACC_W-1:0] S_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - 64'sd1;

   function automatic logic signed [ACC_W-1:0] sat_add(
      input logic signed [ACC_W-1:0] a,
      input logic signed [ACC_W-1:0] b
   );
      logic signed [ACC_W:0] s;
      s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
      if (s > (ACC_W+1)'(ACC_LIM)) begin
         sat_add = ACC_LIM;
      end else if (s < -(ACC_W+1)'(ACC_LIM)) begin
         sat_add = -ACC_LIM;
      end else begin
         sat_add = ACC_W'(s);
      end
   endfunction

   // control state
   logic [ORDER_W-1:0]        sect_cfg_ff, sect_cfg_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic signed [POLE_W-1:0]  pole_ff, pole_in;
   logic [IW-1:0]             n_ff, n_in;
   logic [IW-1:0]             cnt_ff, cnt_in;
   logic                      live_ff, live_in;
   logic                      coef_ok_ff, coef_ok_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mul_op_type                mop_d_ff, mop_d_in;

   // payload
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          start_ff, start_in;
   logic [IW-1:0]                 idx_d_ff, idx_d_in;
   logic signed [POW_W-1:0]       gcl_ff, gcl_in, acl_ff, acl_in;
   logic signed [POW_W-1:0]       gp_ff, gp_in, ap_ff, ap_in;
   logic signed [ACC_W-1:0]       pacc_ff, pacc_in, acc_ff, acc_in, t1_ff, t1_in;
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic [RW-1:0]                 row_ff [0:SECT_MAX];
   logic [RW-1:0]                 row_in [0:SECT_MAX];
   logic signed [CW-1:0]          fc_ff [0:SECT_MAX];
   logic signed [CW-1:0]          fc_in [0:SECT_MAX];
   logic signed [CW-1:0]          bc_ff [1:SECT_MAX];
   logic signed [CW-1:0]          bc_in [1:SECT_MAX];
   logic signed [SAMPLE_BITS-1:0] xh_ff [0:SECT_MAX];
   logic signed [SAMPLE_BITS-1:0] xh_in [0:SECT_MAX];
   logic [HIST_W-1:0]             yh_ff [1:SECT_MAX];
   logic [HIST_W-1:0]             yh_in [1:SECT_MAX];
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;
   logic                          clip_ff, clip_in;

   logic [IW-1:0]             idx;
   logic signed [CW-1:0]      opa;
   logic signed [OPB_W-1:0]   opb;
   logic signed [XW-1:0]      prod_x;
   logic signed [ACC_W-1:0]   prod_sat, pow_full, pow_rnd, y_full, r_full;
   logic signed [POW_W-1:0]   pow_new;
   logic [HIST_W-1:0]         y_new;

   assign idx = cmd.idx[IW-1:0];

   // operand select for the shared multiplier
   always_comb begin
      opa = '0;
      opb = '0;
      case (cmd.mop)
         MOP_GPW_LO: begin
            opa = CW'(gp_ff);
            opb = OPB_W'({1'b0, gcl_ff[RLO_W-1:0]});
         end
         MOP_GPW_HI: begin
            opa = CW'(gp_ff);
            opb = OPB_W'(signed'(gcl_ff[POW_W-1:RLO_W]));
         end
         MOP_APW_LO: begin
            opa = CW'(ap_ff);
            opb = OPB_W'({1'b0, acl_ff[RLO_W-1:0]});
         end
         MOP_APW_HI: begin
            opa = CW'(ap_ff);
            opb = OPB_W'(signed'(acl_ff[POW_W-1:RLO_W]));
         end
         MOP_COEF_F: begin
            opa = CW'(gp_ff);
            opb = OPB_W'({1'b0, row_ff[idx]});
         end
         MOP_COEF_B: begin
            opa = CW'(ap_ff);
            opb = OPB_W'({1'b0, row_ff[idx]});
         end
         MOP_FWD: begin
            opa = coef_ok_ff ? fc_ff[idx] : '0;
            opb = OPB_W'(xh_ff[idx]);
         end
         MOP_FB_HI: begin
            opa = coef_ok_ff ? bc_ff[idx] : '0;
            opb = OPB_W'(signed'(yh_ff[idx][HIST_W-1:YL_W]));
         end
         MOP_FB_LO: begin
            opa = coef_ok_ff ? bc_ff[idx] : '0;
            opb = OPB_W'({1'b0, yh_ff[idx][YL_W-1:0]});
         end
         default: begin
         end
      endcase
   end

   // product saturation and derived values
   always_comb begin
      prod_x = XW'(prod_ff);
      if (prod_x > XW'(ACC_LIM)) begin
         prod_sat = ACC_LIM;
      end else if (prod_x < -XW'(ACC_LIM)) begin
         prod_sat = -ACC_LIM;
      end else begin
         prod_sat = ACC_W'(prod_x);
      end
      pow_full = pacc_ff + (prod_sat <<< RLO_W);
      pow_rnd  = (pow_full + RND29) >>> 30;
      pow_new  = POW_W'(pow_rnd);
      y_full   = (acc_ff + RND13) >>> 14;
      if (y_full > HIST_LIM - 64'sd1) begin
         y_new = HIST_W'(HIST_LIM - 64'sd1);
      end else if (y_full < -HIST_LIM) begin
         y_new = HIST_W'(-HIST_LIM);
      end else begin
         y_new = HIST_W'(y_full);
      end
      r_full = (acc_ff + RND29) >>> 30;
   end

   always_comb begin
      sect_cfg_in  = sect_cfg_ff;
      gain_in      = gain_ff;
      pole_in      = pole_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      live_in      = live_ff;
      coef_ok_in   = coef_ok_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mop_d_in     = cmd.mop;
      idx_d_in     = idx;
      x_in         = x_ff;
      start_in     = start_ff;
      gcl_in       = gcl_ff;
      acl_in       = acl_ff;
      gp_in        = gp_ff;
      ap_in        = ap_ff;
      pacc_in      = pacc_ff;
      acc_in       = acc_ff;
      t1_in        = t1_ff;
      prod_in      = opa * opb;
      row_in       = row_ff;
      fc_in        = fc_ff;
      bc_in        = bc_ff;
      xh_in        = xh_ff;
      yh_in        = yh_ff;
      out_in       = out_ff;
      clip_in      = clip_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ORDER: sect_cfg_in = csr_wdata[ORDER_W-1:0];
            CSR_GAIN:  gain_in     = csr_wdata[GAIN_W-1:0];
            CSR_POLE:  pole_in     = signed'(csr_wdata[POLE_W-1:0]);
            default: begin
            end
         endcase
      end

      // second stage: consume the registered product
      case (mop_d_ff)
         MOP_GPW_LO, MOP_APW_LO: pacc_in = prod_sat;
         MOP_GPW_HI: gp_in = pow_new;
         MOP_APW_HI: ap_in = pow_new;
         MOP_COEF_F: fc_in[idx_d_ff] = prod_ff[CW-1:0];
         MOP_COEF_B: bc_in[idx_d_ff] = prod_ff[CW-1:0];
         MOP_FWD:    acc_in = sat_add(acc_ff, prod_sat);
         MOP_FB_HI:  t1_in = prod_sat;
         MOP_FB_LO:  acc_in = sat_add(acc_ff, -sat_add(t1_ff, prod_sat >>> YL_W));
         default: begin
         end
      endcase

      if (cmd.latch_item) begin
         x_in     = sample_in;
         start_in = record_start;
      end

      if (cmd.load_cfg) begin
         if (sect_cfg_ff == '0) begin
            n_in = IW'(1);
         end else if (int'(sect_cfg_ff) > SECT_MAX) begin
            n_in = N_MAX;
         end else begin
            n_in = IW'(sect_cfg_ff);
         end
         if (gain_ff > GAIN_W'(Q30_ONE)) begin
            gcl_in = Q30_ONE;
         end else begin
            gcl_in = POW_W'({1'b0, gain_ff});
         end
         if (pole_ff > Q30_ONE) begin
            acl_in = Q30_ONE;
         end else if (pole_ff < -Q30_ONE) begin
            acl_in = -Q30_ONE;
         end else begin
            acl_in = pole_ff;
         end
         gp_in      = Q30_ONE;
         ap_in      = Q30_ONE;
         cnt_in     = '0;
         live_in    = 1'b0;
         coef_ok_in = 1'b1;
         for (int q = 0; q <= SECT_MAX; q++) begin
            row_in[q] = '0;
         end
         row_in[0] = RW'(1);
      end

      // one row of pascal's triangle per step, all lanes at once
      if (cmd.binom_step) begin
         for (int q = 1; q <= SECT_MAX; q++) begin
            row_in[q] = row_ff[q] + row_ff[q-1];
         end
      end

      if (cmd.take_sample) begin
         xh_in[0] = x_ff;
         for (int q = 1; q <= SECT_MAX; q++) begin
            xh_in[q] = xh_ff[q-1];
         end
      end

      if (cmd.prime_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end

      // output history starts from the earlier inputs
      if (cmd.seed) begin
         live_in = 1'b1;
         for (int q = 1; q <= SECT_MAX; q++) begin
            yh_in[q] = HIST_W'(xh_ff[q]) << YL_W;
         end
      end

      if (cmd.clear_acc) begin
         acc_in = '0;
      end

      if (cmd.finish) begin
         yh_in[1] = y_new;
         for (int q = 2; q <= SECT_MAX; q++) begin
            yh_in[q] = yh_ff[q-1];
         end
         rsp_valid_in = 1'b1;
         if (r_full > S_MAX) begin
            out_in  = SAMPLE_BITS'(S_MAX);
            clip_in = 1'b1;
         end else if (r_full < S_MIN) begin
            out_in  = SAMPLE_BITS'(S_MIN);
            clip_in = 1'b1;
         end else begin
            out_in  = SAMPLE_BITS'(r_full);
            clip_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sect_cfg_ff  <= ORDER_RST;
         gain_ff      <= GAIN_RST;
         pole_ff      <= '0;
         n_ff         <= N_RST;
         cnt_ff       <= '0;
         live_ff      <= 1'b0;
         coef_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mop_d_ff     <= MOP_NONE;
      end else begin
         sect_cfg_ff  <= sect_cfg_in;
         gain_ff      <= gain_in;
         pole_ff      <= pole_in;
         n_ff         <= n_in;
         cnt_ff       <= cnt_in;
         live_ff      <= live_in;
         coef_ok_ff   <= coef_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         mop_d_ff     <= mop_d_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff <= idx_d_in;
      x_ff     <= x_in;
      start_ff <= start_in;
      gcl_ff   <= gcl_in;
      acl_ff   <= acl_in;
      gp_ff    <= gp_in;
      ap_ff    <= ap_in;
      pacc_ff  <= pacc_in;
      acc_ff   <= acc_in;
      t1_ff    <= t1_in;
      prod_ff  <= prod_in;
      row_ff   <= row_in;
      fc_ff    <= fc_in;
      bc_ff    <= bc_in;
      xh_ff    <= xh_in;
      yh_ff    <= yh_in;
      out_ff   <= out_in;
      clip_ff  <= clip_in;
   end

   assign stat.order      = IDX_W'(n_ff);
   assign stat.start_flag = start_ff;
   assign stat.primed     = (cnt_ff == n_ff);
   assign stat.live       = live_ff;
   assign stat.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign sample_out = out_ff;
   assign clipped    = clip_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cblp_ctrl.sv
// controller: sequences coefficient setup and per-sample multiply-accumulate
// depends on cblp_pkg and the assertion macro header
`default_nettype none

module cblp_ctrl #(
   parameter int SECT_MAX = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cblp_pkg::dp_stat_type stat,
   output cblp_pkg::dp_cmd_type  cmd
);
   import cblp_pkg::*;

   localparam int IW = $clog2(SECT_MAX + 1);

   typedef enum logic [17:0] {
      S_IDLE  = 18'h00001,
      S_CHECK = 18'h00002,
      S_BINOM = 18'h00004,
      S_GLO   = 18'h00008,
      S_GHI   = 18'h00010,
      S_GWAIT = 18'h00020,
      S_FWDC  = 18'h00040,
      S_ALO   = 18'h00080,
      S_AHI   = 18'h00100,
      S_AWAIT = 18'h00200,
      S_FBC   = 18'h00400,
      S_SHIFT = 18'h00800,
      S_SEED  = 18'h01000,
      S_MACF  = 18'h02000,
      S_MBH   = 18'h04000,
      S_MBL   = 18'h08000,
      S_DRAIN = 18'h10000,
      S_DONE  = 18'h20000
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] k_ff, k_in;
   logic [IW-1:0] n;
   logic [IW-1:0] k_inc;
   logic          k_last;

   assign n      = stat.order[IW-1:0];
   assign k_inc  = k_ff + 1'b1;
   assign k_last = (k_ff == n);

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mop   = MOP_NONE;
      cmd.idx   = IDX_W'(k_ff);
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.start_flag) begin
               cmd.load_cfg = 1'b1;
               k_in         = IW'(1);
               state_in     = S_BINOM;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_BINOM: begin
            cmd.binom_step = 1'b1;
            if (k_last) begin
               k_in     = '0;
               state_in = S_GLO;
            end else begin
               k_in = k_inc;
            end
         end
         S_GLO: begin
            cmd.mop  = MOP_GPW_LO;
            state_in = S_GHI;
         end
         S_GHI: begin
            cmd.mop  = MOP_GPW_HI;
            state_in = S_GWAIT;
         end
         // gain power lands at the end of this cycle
         S_GWAIT: begin
            if (k_inc == n) begin
               k_in     = '0;
               state_in = S_FWDC;
            end else begin
               k_in     = k_inc;
               state_in = S_GLO;
            end
         end
         S_FWDC: begin
            cmd.mop = MOP_COEF_F;
            if (k_last) begin
               k_in     = IW'(1);
               state_in = S_ALO;
            end else begin
               k_in = k_inc;
            end
         end
         S_ALO: begin
            cmd.mop  = MOP_APW_LO;
            state_in = S_AHI;
         end
         S_AHI: begin
            cmd.mop  = MOP_APW_HI;
            state_in = S_AWAIT;
         end
         S_AWAIT: begin
            state_in = S_FBC;
         end
         S_FBC: begin
            cmd.mop = MOP_COEF_B;
            if (k_last) begin
               state_in = S_SHIFT;
            end else begin
               k_in     = k_inc;
               state_in = S_ALO;
            end
         end
         S_SHIFT: begin
            cmd.take_sample = 1'b1;
            if (stat.live) begin
               cmd.clear_acc = 1'b1;
               k_in          = '0;
               state_in      = S_MACF;
            end else if (stat.primed) begin
               state_in = S_SEED;
            end else begin
               cmd.prime_inc = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SEED: begin
            cmd.seed      = 1'b1;
            cmd.clear_acc = 1'b1;
            k_in          = '0;
            state_in      = S_MACF;
         end
         S_MACF: begin
            cmd.mop = MOP_FWD;
            if (k_last) begin
               k_in     = IW'(1);
               state_in = S_MBH;
            end else begin
               k_in = k_inc;
            end
         end
         S_MBH: begin
            cmd.mop  = MOP_FB_HI;
            state_in = S_MBL;
         end
         S_MBL: begin
            cmd.mop = MOP_FB_LO;
            if (k_last) begin
               state_in = S_DRAIN;
            end else begin
               k_in     = k_inc;
               state_in = S_MBH;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

`include "cascaded_bilinear_lowpass_iir_unit_assert.svh"

   `CBLP_AST_NOW(a_finish_free, clock, reset, cmd.finish, stat.out_free, "result overwritten")
   `CBLP_AST_NOW(a_k_bound, clock, reset, state_ff == S_MACF || state_ff == S_MBH || state_ff == S_MBL || state_ff == S_FWDC, k_ff <= n, "tap index past order")
   `CBLP_AST_NEXT(a_accept_check, clock, reset, req_valid && req_ready, state_ff == S_CHECK, "accepted beat not checked")
   `CBLP_AST_NEXT(a_done_idle, clock, reset, state_ff == S_DONE && stat.out_free, state_ff == S_IDLE, "result not handed off")

endmodule

`default_nettype wire

>>> dv/cascaded_bilinear_lowpass_iir_unit_test.sv
// self-checking testbench for the cascaded bilinear low-pass iir filter
// depends on cblp_pkg, cblp_stream_if and the cascaded_bilinear_lowpass_iir_unit rtl
// a scoreboard class predicts every result from the accepted beats and register writes
`default_nettype none

typedef struct {
   logic signed [15:0] sample;
   logic               clip;
} filtered_sample_type;

class lowpass_scoreboard_type;
   localparam longint ACC_CAP  = 64'sh4000_0000_0000_0000;
   localparam longint HIST_CAP = 64'sd549755813888;
   localparam longint Q30      = 64'sd1073741824;

   logic [3:0]  order_reg;
   logic [30:0] gain_reg;
   logic [31:0] pole_reg;
   longint      x_hist[11];
   longint      y_hist[11];
   longint      fwd_tab[11];
   longint      fb_tab[11];
   longint      pascal[11];
   int          primed_cnt;
   int          order_live;
   filtered_sample_type awaited[$];
   int          errors;

   function new();
      order_reg  = 4'd2;
      gain_reg   = 31'd536870912;
      pole_reg   = '0;
      primed_cnt = 0;
      order_live = 2;
      errors     = 0;
      for (int i = 0; i <= 10; i++) begin
         x_hist[i] = 0; y_hist[i] = 0; fwd_tab[i] = 0; fb_tab[i] = 0; pascal[i] = 0;
      end
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
         cblp_pkg::CSR_ORDER: order_reg = data[3:0];
         cblp_pkg::CSR_GAIN:  gain_reg  = data[30:0];
         cblp_pkg::CSR_POLE:  pole_reg  = data;
         default: ;
      endcase
   endfunction

   function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function longint sat_add(longint a, longint b);
      return clamp(a + b, -ACC_CAP, ACC_CAP);
   endfunction

   function longint sat_mul(longint a, longint b);
      longint unsigned ua, ub, p;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      if (ua != 0 && ub > longint'(ACC_CAP) / ua) p = ACC_CAP;
      else p = ua * ub;
      if (p > ACC_CAP) p = ACC_CAP;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   function longint round_q30(longint p, longint r);
      return (p * r + (64'sd1 << 29)) >>> 30;
   endfunction

   // rebuild both coefficient tables for the latched order
   function void begin_record();
      int n;
      longint g, a, gp, ap;
      n  = order_reg == 0 ? 1 : (order_reg > 10 ? 10 : order_reg);
      g  = clamp(longint'(gain_reg), 0, Q30);
      a  = clamp(longint'(signed'(pole_reg)), -Q30, Q30);
      gp = Q30;
      ap = Q30;
      for (int i = 0; i <= 10; i++) begin
         x_hist[i] = 0; y_hist[i] = 0; fwd_tab[i] = 0; fb_tab[i] = 0; pascal[i] = 0;
      end
      pascal[0] = 1;
      for (int p = 1; p <= n; p++)
         for (int q = p; q >= 1; q--) pascal[q] += pascal[q-1];
      for (int p = 0; p < n; p++) gp = round_q30(gp, g);
      for (int q = 0; q <= n; q++) fwd_tab[q] = gp * pascal[q];
      for (int q = 1; q <= n; q++) begin
         ap = round_q30(ap, a);
         fb_tab[q] = ap * pascal[q];
      end
      order_live = n;
      primed_cnt = 0;
   endfunction

   function void note_beat(logic signed [15:0] sample, logic start);
      int n;
      longint acc, hi, lo, t, ynew, r;
      filtered_sample_type res;
      if (start) begin_record();
      n = order_live;
      for (int i = n; i >= 1; i--) x_hist[i] = x_hist[i-1];
      x_hist[0] = sample;
      if (primed_cnt < n) begin
         primed_cnt++;
         return;
      end
      if (primed_cnt == n) begin
         // output history seeded from the older inputs
         for (int i = 1; i <= n; i++) y_hist[i] = x_hist[i] * 65536;
         primed_cnt = n + 1;
      end
      acc = 0;
      for (int i = 0; i <= n; i++) acc = sat_add(acc, sat_mul(fwd_tab[i], x_hist[i]));
      for (int i = 1; i <= n; i++) begin
         hi  = y_hist[i] >>> 16;
         lo  = y_hist[i] - hi * 65536;
         t   = sat_add(sat_mul(fb_tab[i], hi), sat_mul(fb_tab[i], lo) >>> 16);
         acc = sat_add(acc, -t);
      end
      ynew = clamp((acc + (64'sd1 << 13)) >>> 14, -HIST_CAP, HIST_CAP - 1);
      for (int i = n; i >= 2; i--) y_hist[i] = y_hist[i-1];
      y_hist[1] = ynew;
      r = (acc + (64'sd1 << 29)) >>> 30;
      res.clip = 1'b0;
      if (r > 32767) begin
         r = 32767; res.clip = 1'b1;
      end else if (r < -32768) begin
         r = -32768; res.clip = 1'b1;
      end
      res.sample = r[15:0];
      awaited.push_back(res);
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_result(logic signed [15:0] sample, logic clip);
      filtered_sample_type exp_res;
      if (awaited.size() == 0) begin
         report($sformatf("unexpected result %0d clip %0b", sample, clip));
         return;
      end
      exp_res = awaited.pop_front();
      if (sample !== exp_res.sample)
         report($sformatf("sample_out %0d, predicted %0d", sample, exp_res.sample));
      if (clip !== exp_res.clip)
         report($sformatf("clipped %0b, predicted %0b", clip, exp_res.clip));
   endtask
endclass

module cascaded_bilinear_lowpass_iir_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMEOUT_CYCLES = 1_500_000;
   localparam int SETTLE_CYCLES  = 160;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          send_idle_pct;
   int          stall_pct;
   int          cycles;
   int          beats_sent;
   lowpass_scoreboard_type sb;

   cblp_req_if #(.SAMPLE_BITS(16)) req ();
   cblp_rsp_if #(.SAMPLE_BITS(16)) rsp ();

   cascaded_bilinear_lowpass_iir_unit #(.SECT_MAX(10), .SAMPLE_BITS(16)) dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) sb.note_beat(req.sample_in, req.record_start);
      if (!reset && rsp.valid && rsp.ready) sb.check_result(rsp.sample_out, rsp.clipped);
   end

   task write_csr(logic [1:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task send_beat(logic signed [15:0] sample, logic start);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req.valid        <= 1'b1;
      req.sample_in    <= sample;
      req.record_start <= start;
      do @(posedge clock); while (!req.ready);
      beats_sent++;
   endtask

   task drain();
      req.valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function logic signed [15:0] pick_sample();
      case ($urandom_range(19))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task set_filter(logic [3:0] n, logic [31:0] g, logic [31:0] a);
      write_csr(cblp_pkg::CSR_ORDER, {28'd0, n});
      write_csr(cblp_pkg::CSR_GAIN, g);
      write_csr(cblp_pkg::CSR_POLE, a);
   endtask

   initial begin
      int rec;
      int len;
      logic [31:0] g;
      sb               = new();
      cycles           = 0;
      beats_sent       = 0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req.valid        = 1'b0;
      req.sample_in    = '0;
      req.record_start = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no start since reset: zero tables, default order
      send_beat(16'sh7fff, 1'b0);
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sh7fff, 1'b0);
      send_beat(16'sh8000, 1'b0);
      drain();

      // order zero acts as one, full gain, pole at its negative limit
      set_filter(4'd0, 32'd1073741824, 32'hc000_0000);
      send_beat(16'sh7fff, 1'b1);
      send_beat(16'sh7fff, 1'b0);
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sh8000, 1'b0);
      send_beat(16'sh5555, 1'b0);
      drain();

      // order, gain and pole beyond range all saturate; unstable so it clips
      set_filter(4'd15, 32'h7fff_ffff, 32'h7fff_ffff);
      for (int i = 0; i < 12; i++) send_beat(i[0] ? 16'sh8000 : 16'sh7fff, i == 0);
      drain();

      // zero gain, most negative pole word; order change mid-record is held off
      set_filter(4'd1, 32'd0, 32'h8000_0000);
      send_beat(16'shaaaa, 1'b1);
      send_beat(16'sh1234, 1'b0);
      drain();
      write_csr(cblp_pkg::CSR_ORDER, 32'd5);
      send_beat(16'sh7fff, 1'b0);
      send_beat(16'sh8000, 1'b0);
      drain();

      rec = 0;
      while (beats_sent < 1420) begin
         case ((rec / 6) % 5)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            3: begin send_idle_pct = 29; stall_pct = 29; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         if ($urandom_range(9) < 7) begin
            drain();
            g = $urandom_range(0, 1073741824);
            if ($urandom_range(9) < 8)
               // matched bilinear pair: a = 2g - 1 in Q1.30
               set_filter(4'($urandom_range(9) < 8 ? $urandom_range(1, 4)
                                                   : $urandom_range(0, 15)),
                          g, 2 * g - 32'd1073741824);
            else
               set_filter(4'($urandom), $urandom, $urandom);
         end
         len = $urandom_range(1, 40);
         for (int i = 0; i < len; i++)
            send_beat(pick_sample(), i == 0 ? ($urandom_range(9) != 0)
                                            : ($urandom_range(49) == 0));
         rec++;
      end
      drain();

      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

`default_nettype wire
